/* rtl/arpc_pkg.sv */
// Shared types and constants of the ARP cache and responder.
// Used by arpc_ctrl, arpc_dp and arp_cache_and_responder_top; depends on nothing.
`default_nettype none

package arpc_pkg;

  // Table size default; the top level hands it down as a parameter.
  localparam int ARPC_TABLE_ENTRIES = 16;

  // Field widths.
  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int MODE_W  = 2;
  localparam int HALF_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PACKET = 2'd2;

  // Packet checks.
  localparam logic [HALF_W-1:0] MIN_FRAME_LEN = 16'd42;
  localparam logic [HALF_W-1:0] HW_ETHERNET   = 16'h0001;
  localparam logic [HALF_W-1:0] PROTO_IPV4    = 16'h0800;
  localparam logic [HALF_W-1:0] OP_REQUEST    = 16'h0001;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the accepted item
    logic scan_start;  // restart the table scan at entry zero
    logic scan_run;    // scan in progress
    logic wr_en;       // write the learnt entry
    logic out_load;    // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;         // compare stage matched a valid entry
    logic miss_done;   // last entry compared without a match
    logic learn;       // current item writes the table
  } sts_t;

endpackage

`default_nettype wire

/* rtl/arpc_ctrl.sv */
// Controller of the ARP cache: sequences capture, scan, table write and result.
// Depends on arpc_pkg.
`default_nettype none

module arpc_ctrl
  import arpc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  sts_t      sts,
  output cmd_t      cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       in_xfer;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.scan_run   = (state == S_SCAN);
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.hit || sts.miss_done) begin
          state_next = sts.learn ? S_WRITE : S_DONE;
        end
      end
      S_WRITE: begin
        cmd.wr_en  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold the result until its transfer
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // An accepted item always starts a scan
  a_accept_scans: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_SCAN)
    else $error("accepted item did not start a scan");

  // A result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // A table write follows only a finished scan of a learning item
  a_write_after_scan: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |-> $past(state) == S_SCAN && $past(sts.learn))
    else $error("table write without a preceding scan");

endmodule

`default_nettype wire

/* rtl/arpc_dp.sv */
// Datapath of the ARP cache: item and config registers, entry memory, valid
// bits, scan compare stage, round-robin slot and result register. Depends on arpc_pkg.
`default_nettype none

module arpc_dp
  import arpc_pkg::*;
#(
  parameter int TABLE_ENTRIES = ARPC_TABLE_ENTRIES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  input  wire logic [MODE_W-1:0]     mode,
  input  wire logic [IP_W-1:0]       ip_addr,
  input  wire logic [MAC_W-1:0]      mac_addr,
  input  wire logic [HALF_W-1:0]     frame_length,
  input  wire logic [HALF_W-1:0]     hw_type,
  input  wire logic [HALF_W-1:0]     proto_type,
  input  wire logic [HALF_W-1:0]     operation,
  input  wire logic [IP_W-1:0]       target_ip,
  input  wire logic                  cfg_wr,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       found,
  output logic [MAC_W-1:0]           found_mac,
  output logic                       reply_valid,
  output logic [MAC_W-1:0]           reply_mac,
  output logic [IP_W-1:0]            reply_ip
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);
  localparam int ENT_W = IP_W + MAC_W;

  // Configuration registers
  logic [IP_W-1:0]  own_ip;
  logic [MAC_W-1:0] own_mac;

  // Captured item, reduced to what the work needs
  logic             lookup_q;
  logic             learn_q;
  logic             reply_q;
  logic [IP_W-1:0]  ip_q;
  logic [MAC_W-1:0] mac_q;

  // Entry store and scan
  logic [ENT_W-1:0]         mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [ENT_W-1:0]         rd_data;
  logic [IDX_W-1:0]         cnt;
  logic                     issue_on;
  logic                     cmp_en;
  logic [IDX_W-1:0]         cmp_idx;
  logic [IDX_W-1:0]         next_slot;
  logic                     hit_flag;
  logic [IDX_W-1:0]         hit_idx;
  logic [MAC_W-1:0]         hit_mac;
  logic [IDX_W-1:0]         wr_addr;
  logic                     pkt_ok;
  logic                     cmp_hit;

  // Classify the incoming item
  assign pkt_ok = (mode == MODE_PACKET) && (frame_length >= MIN_FRAME_LEN)
                  && (hw_type == HW_ETHERNET) && (proto_type == PROTO_IPV4);

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= '0;
      own_mac <= '0;
    end else if (cfg_wr) begin
      if (cfg_index == REG_OWN_IP) begin
        own_ip <= cfg_data[IP_W-1:0];
      end else if (cfg_index == REG_OWN_MAC) begin
        own_mac <= cfg_data[MAC_W-1:0];
      end
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lookup_q <= (mode == MODE_LOOKUP);
      learn_q  <= (mode == MODE_ADD) || pkt_ok;
      reply_q  <= pkt_ok && (operation == OP_REQUEST) && (target_ip == own_ip);
      ip_q     <= ip_addr;
      mac_q    <= mac_addr;
    end
  end

  // Issue one read per cycle; compare the returned entry in the following cycle
  assign cmp_hit = cmp_en && entry_valid[cmp_idx] && (rd_data[ENT_W-1:MAC_W] == ip_q);
  assign sts.hit       = cmp_hit;
  assign sts.miss_done = cmp_en && (cmp_idx == LAST) && !cmp_hit;
  assign sts.learn     = learn_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_on <= 1'b0;
      cmp_en   <= 1'b0;
      cnt      <= '0;
    end else begin
      cmp_en <= issue_on && cmd.scan_run;
      if (cmd.scan_start) begin
        cnt      <= '0;
        issue_on <= 1'b1;
      end else if (issue_on && cmd.scan_run) begin
        if (cnt == LAST) begin
          issue_on <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= cnt;
  end

  // Record the first match of the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_flag <= 1'b0;
    end else if (cmd.scan_start) begin
      hit_flag <= 1'b0;
    end else if (cmd.scan_run && cmp_hit) begin
      hit_flag <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_run && cmp_hit) begin
      hit_idx <= cmp_idx;
      hit_mac <= rd_data[MAC_W-1:0];
    end
  end

  // Update the matching entry, else take the round-robin slot
  assign wr_addr = hit_flag ? hit_idx : next_slot;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= {ip_q, mac_q};
    end
    rd_data <= mem[cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      next_slot   <= '0;
    end else if (cmd.wr_en && !hit_flag) begin
      entry_valid[next_slot] <= 1'b1;
      next_slot <= (next_slot == LAST) ? '0 : next_slot + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found       <= lookup_q && hit_flag;
      found_mac   <= (lookup_q && hit_flag) ? hit_mac : '0;
      reply_valid <= reply_q;
      reply_mac   <= reply_q ? mac_q : '0;
      reply_ip    <= reply_q ? ip_q : '0;
    end
  end

  // The round-robin slot stays inside the table
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    next_slot <= LAST)
    else $error("round-robin slot out of range");

  // An insertion leaves its slot valid
  a_insert_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en && !hit_flag |=> entry_valid[$past(next_slot)])
    else $error("inserted entry not marked valid");

  // The table is never written while it is being scanned
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> !cmd.scan_run)
    else $error("table write during scan");

endmodule

`default_nettype wire

/* rtl/arp_cache_and_responder_top.sv */
// Top level of the ARP cache and responder: controller plus datapath.
// Depends on arpc_pkg, arpc_ctrl and arpc_dp.
//
// Every accepted item gives one result. An item is accepted only when the
// block is idle; it then scans the table one entry per cycle from index
// zero through the single read port of the entry memory, stopping at the
// first valid match, then writes the table in add or learn mode and
// waits, if needed, for the result register to drain before loading the
// result. The next item is taken as soon as the result is loaded.
// own_ip and own_mac are written over the configuration channel (index
// 0 and 1, always ready); own_mac is stored but appears in no result.
// No clearing pass runs after reset.
`default_nettype none

module arp_cache_and_responder_top
  import arpc_pkg::*;
#(
  parameter int TABLE_ENTRIES = ARPC_TABLE_ENTRIES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [MODE_W-1:0]     mode,
  input  wire logic [IP_W-1:0]       ip_addr,
  input  wire logic [MAC_W-1:0]      mac_addr,
  input  wire logic [HALF_W-1:0]     frame_length,
  input  wire logic [HALF_W-1:0]     hw_type,
  input  wire logic [HALF_W-1:0]     proto_type,
  input  wire logic [HALF_W-1:0]     operation,
  input  wire logic [IP_W-1:0]       target_ip,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       found,
  output logic [MAC_W-1:0]           found_mac,
  output logic                       reply_valid,
  output logic [MAC_W-1:0]           reply_mac,
  output logic [IP_W-1:0]            reply_ip,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // Configuration writes are taken at once
  assign cfg_ready = 1'b1;

  arpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  arpc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .mode         (mode),
    .ip_addr      (ip_addr),
    .mac_addr     (mac_addr),
    .frame_length (frame_length),
    .hw_type      (hw_type),
    .proto_type   (proto_type),
    .operation    (operation),
    .target_ip    (target_ip),
    .cfg_wr       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .found        (found),
    .found_mac    (found_mac),
    .reply_valid  (reply_valid),
    .reply_mac    (reply_mac),
    .reply_ip     (reply_ip)
  );

endmodule

`default_nettype wire
